// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: command codes and
// the record that travels from the command unit to the result stage.
// ----------------------------------------------------------------------------
package deq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SIZE       = 3'd4,
        OP_EMPTY      = 3'd5,
        OP_FRONT      = 3'd6,
        OP_BACK       = 3'd7
    } opcode_t;

    localparam int WORD_W = 32;

    // Returned by a pop or peek that finds the queue empty.
    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    typedef struct packed {
        logic              from_mem;
        logic [WORD_W-1:0] value;
        logic              was_empty;
        logic              overflow;
    } rsp_info_t;

endpackage

// ===== sv/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== sv/deq_cmd.sv =====
// ----------------------------------------------------------------------------
// deq_cmd
// Command unit: holds the head pointer, count and overflow flag, and issues at
// most one store access per accepted item (a write for a push into a non-full
// queue, a read for a pop or peek of a non-empty queue).
// ----------------------------------------------------------------------------
module deq_cmd #(
    parameter int DEPTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic [2:0]                   opcode,
    input  logic [deq_pkg::WORD_W-1:0]   push_value,
    output logic                         ram_en,
    output logic                         ram_we,
    output logic [$clog2(DEPTH)-1:0]     ram_addr,
    output logic [deq_pkg::WORD_W-1:0]   ram_wdata,
    output logic                         issue_valid,
    output deq_pkg::rsp_info_t           issue_info
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;

    logic          is_empty, is_full;
    logic [AW-1:0] head_dec, head_inc;
    logic [SW-1:0] push_sum, back_sum, push_wrap, back_wrap;
    logic [AW-1:0] push_idx, back_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb begin
        is_empty = (count_reg == '0);
        is_full  = (count_reg == CW'(DEPTH));
        head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
        head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        // Both sums stay below twice the depth, so one conditional subtract wraps them.
        push_sum  = SW'(head_reg) + SW'(count_reg);
        back_sum  = push_sum - SW'(1);
        push_wrap = (push_sum >= SW'(DEPTH)) ? push_sum - SW'(DEPTH) : push_sum;
        back_wrap = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
        push_idx  = push_wrap[AW-1:0];
        back_idx  = back_wrap[AW-1:0];
    end

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = head_reg;
        ram_wdata   = push_value;
        issue_valid = 1'b0;
        issue_info.from_mem  = 1'b0;
        issue_info.value     = deq_pkg::EMPTY_WORD;
        issue_info.was_empty = 1'b0;
        issue_info.overflow  = ovf_reg;

        if (accept) begin
            case (deq_pkg::opcode_t'(opcode))
                deq_pkg::OP_PUSH_FRONT: begin
                    if (is_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        ram_en     = 1'b1;
                        ram_we     = 1'b1;
                        ram_addr   = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                deq_pkg::OP_PUSH_BACK: begin
                    if (is_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        ram_en     = 1'b1;
                        ram_we     = 1'b1;
                        ram_addr   = push_idx;
                        count_next = count_reg + CW'(1);
                    end
                end
                deq_pkg::OP_POP_FRONT, deq_pkg::OP_FRONT: begin
                    issue_valid          = 1'b1;
                    issue_info.from_mem  = !is_empty;
                    issue_info.was_empty = is_empty;
                    ram_en   = !is_empty;
                    ram_addr = head_reg;
                    if (!is_empty && opcode == deq_pkg::OP_POP_FRONT) begin
                        head_next  = head_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                deq_pkg::OP_POP_BACK, deq_pkg::OP_BACK: begin
                    issue_valid          = 1'b1;
                    issue_info.from_mem  = !is_empty;
                    issue_info.was_empty = is_empty;
                    ram_en   = !is_empty;
                    ram_addr = back_idx;
                    if (!is_empty && opcode == deq_pkg::OP_POP_BACK) begin
                        count_next = count_reg - CW'(1);
                    end
                end
                deq_pkg::OP_SIZE: begin
                    issue_valid      = 1'b1;
                    issue_info.value = deq_pkg::WORD_W'(count_reg);
                end
                deq_pkg::OP_EMPTY: begin
                    issue_valid      = 1'b1;
                    issue_info.value = deq_pkg::WORD_W'(is_empty);
                end
                default: begin
                    issue_valid = 1'b0;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");
`endif

endmodule

// ===== sv/deq_rsp.sv =====
// ----------------------------------------------------------------------------
// deq_rsp
// Result stage: holds each item in a pending register while the store's read data
// arrives, then moves it into the output register. A stalled pending item keeps its read data.
// ----------------------------------------------------------------------------
module deq_rsp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         issue_valid,
    input  deq_pkg::rsp_info_t           issue_info,
    input  logic [deq_pkg::WORD_W-1:0]   ram_rdata,
    output logic                         take_ok,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [deq_pkg::WORD_W-1:0]   m_result_value,
    output logic                         m_was_empty,
    output logic                         m_overflow_seen
);

    logic                       pend_valid_reg;
    deq_pkg::rsp_info_t         pend_info_reg;
    logic                       out_valid_reg;
    logic [deq_pkg::WORD_W-1:0] out_value_reg;
    logic                       out_empty_reg;
    logic                       out_ovf_reg;

    logic                       out_free, pend_adv;
    logic [deq_pkg::WORD_W-1:0] pend_value;

    always_comb begin
        out_free   = !out_valid_reg || m_ready;
        pend_adv   = pend_valid_reg && out_free;
        take_ok    = !pend_valid_reg || out_free;
        pend_value = pend_info_reg.from_mem ? ram_rdata : pend_info_reg.value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (issue_valid) begin
            pend_valid_reg <= 1'b1;
        end else if (pend_adv) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_valid) begin
            pend_info_reg <= issue_info;
        end else if (pend_valid_reg && !out_free) begin
            // Keep the read word locally while the output is held.
            pend_info_reg.value    <= pend_value;
            pend_info_reg.from_mem <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pend_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_adv) begin
            out_value_reg <= pend_value;
            out_empty_reg <= pend_info_reg.was_empty;
            out_ovf_reg   <= pend_info_reg.overflow;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_value  = out_value_reg;
    assign m_was_empty     = out_empty_reg;
    assign m_overflow_seen = out_ovf_reg;

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_valid |-> (!pend_valid_reg || out_free))
        else $error("item issued into an occupied result stage");
    a_pend_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !out_free) |=> pend_valid_reg)
        else $error("stalled result item was lost");
    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_empty_reg) |-> (out_value_reg == deq_pkg::EMPTY_WORD))
        else $error("empty result without the empty word");
`endif

endmodule

// ===== sv/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit words in a circular single-port store.
//
//   channel  direction  ports
//   s_       in         s_valid, s_ready, s_opcode, s_push_value
//   m_       out        m_valid, m_ready, m_result_value, m_was_empty,
//                       m_overflow_seen
//
// One command is accepted per cycle while s_ready is high; each uses the store's
// single port at most once (a write for a push, a read for a pop or peek).
// An accepted item's result passes through the read stage, where the store's
// registered read data arrives, and then into the output register.
// Reset clears the head pointer, count and overflow flag; the store is not
// cleared and needs no pass after reset.
// When the output is held, one more result waits in the read stage and
// s_ready drops until the output register is taken.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_opcode,
    input  logic signed [31:0]   s_push_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_result_value,
    output logic                 m_was_empty,
    output logic                 m_overflow_seen
);

    localparam int AW = $clog2(DEPTH);

    logic                       accept;
    logic                       ram_en, ram_we;
    logic [AW-1:0]              ram_addr;
    logic [deq_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
    logic                       issue_valid;
    deq_pkg::rsp_info_t         issue_info;
    logic [deq_pkg::WORD_W-1:0] result_bits;

    assign accept = s_valid && s_ready;

    deq_cmd #(
        .DEPTH(DEPTH)
    ) u_cmd (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .opcode     (s_opcode),
        .push_value (s_push_value),
        .ram_en     (ram_en),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .issue_valid(issue_valid),
        .issue_info (issue_info)
    );

    deq_ram #(
        .WIDTH(deq_pkg::WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    deq_rsp u_rsp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .issue_valid    (issue_valid),
        .issue_info     (issue_info),
        .ram_rdata      (ram_rdata),
        .take_ok        (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (result_bits),
        .m_was_empty    (m_was_empty),
        .m_overflow_seen(m_overflow_seen)
    );

    assign m_result_value = $signed(result_bits);

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended queue. Commands flow in through a
// queue of pending items. A mirror of the deque predicts each result when its
// command is accepted, and the monitor checks every result taken from the
// output channel against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH       = 1024;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct {
        deq_pkg::opcode_t   op;
        logic signed [31:0] word;
        bit                 hold;
    } command_t;

    typedef struct {
        logic signed [31:0] value;
        logic               was_empty;
        logic               overflow;
    } deque_result_t;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_opcode        = 3'd0;
    logic signed [31:0]   s_push_value    = 32'sd0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic signed [31:0]   m_result_value;
    logic                 m_was_empty;
    logic                 m_overflow_seen;

    command_t      pending_cmds[$];
    deque_result_t expected_results[$];

    // Mirror of the deque.
    logic [31:0]      mirror_mem [DEPTH];
    logic [PTR_W-1:0] mirror_head  = '0;
    logic [PTR_W:0]   mirror_count = '0;
    logic             mirror_ovf   = 1'b0;

    int  cmds_issued   = 0;
    int  cmds_taken    = 0;
    int  results_taken = 0;
    int  results_seen  = 0;
    int  cycle_count   = 0;
    int  tx_gap        = 0;
    int  rx_stall      = 0;
    bit  tx_calm       = 1'b0;
    bit  rx_calm       = 1'b0;
    bit  failed        = 1'b0;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_push_value    (s_push_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_was_empty     (m_was_empty),
        .m_overflow_seen (m_overflow_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Applies one command to the mirror and records the result it gives; a push gives no result.
    task automatic apply_deque_command(input deq_pkg::opcode_t op,
                                       input logic [31:0] word);
        deque_result_t    res;
        logic [PTR_W-1:0] slot;
        res.value     = '0;
        res.was_empty = 1'b0;
        res.overflow  = 1'b0;
        case (op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                if (mirror_count == DEPTH) begin
                    mirror_ovf = 1'b1;
                end else if (op == deq_pkg::OP_PUSH_FRONT) begin
                    mirror_head             = mirror_head - 1'b1;
                    mirror_mem[mirror_head] = word;
                    mirror_count            = mirror_count + 1'b1;
                end else begin
                    slot             = mirror_head + mirror_count[PTR_W-1:0];
                    mirror_mem[slot] = word;
                    mirror_count     = mirror_count + 1'b1;
                end
                return;
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_FRONT: begin
                if (mirror_count == 0) begin
                    res.value     = deq_pkg::EMPTY_WORD;
                    res.was_empty = 1'b1;
                end else begin
                    res.value = mirror_mem[mirror_head];
                    if (op == deq_pkg::OP_POP_FRONT) begin
                        mirror_head  = mirror_head + 1'b1;
                        mirror_count = mirror_count - 1'b1;
                    end
                end
            end
            deq_pkg::OP_POP_BACK, deq_pkg::OP_BACK: begin
                if (mirror_count == 0) begin
                    res.value     = deq_pkg::EMPTY_WORD;
                    res.was_empty = 1'b1;
                end else begin
                    slot      = mirror_head + mirror_count[PTR_W-1:0] - 1'b1;
                    res.value = mirror_mem[slot];
                    if (op == deq_pkg::OP_POP_BACK) begin
                        mirror_count = mirror_count - 1'b1;
                    end
                end
            end
            deq_pkg::OP_SIZE: begin
                res.value = 32'(mirror_count);
            end
            default: begin
                res.value = (mirror_count == 0) ? 32'sd1 : 32'sd0;
            end
        endcase
        res.overflow = mirror_ovf;
        expected_results.insert(expected_results.size(), res);
    endtask

    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic deq_pkg::opcode_t random_opcode(input int push_pct);
        if ($urandom_range(0, 99) < push_pct) begin
            return $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
        end
        return deq_pkg::opcode_t'($urandom_range(2, 7));
    endfunction

    task automatic queue_command(input deq_pkg::opcode_t op,
                                 input logic signed [31:0] word,
                                 input bit hold);
        command_t cmd;
        cmd.op   = op;
        cmd.word = word;
        cmd.hold = hold;
        pending_cmds.insert(pending_cmds.size(), cmd);
    endtask

    // Command driver: holds each item until it is taken, then idles for a
    // random gap before the next one.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && cmds_taken != cmds_issued) begin
            // Item still waiting for acceptance.
        end else if (tx_gap > 0) begin
            s_valid <= 1'b0;
            tx_gap  = tx_gap - 1;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].hold && expected_results.size() != 0)) begin
            s_valid      <= 1'b1;
            s_opcode     <= pending_cmds[0].op;
            s_push_value <= pending_cmds[0].word;
            pending_cmds.delete(0);
            cmds_issued = cmds_issued + 1;
            if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
            tx_gap = tx_calm ? 0 : $urandom_range(0, 9);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result receiver: stalls for a random number of cycles after each result.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (results_seen != results_taken) begin
                results_seen = results_taken;
                if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
                rx_stall = rx_calm ? 0 : $urandom_range(0, 9);
            end
            if (rx_stall > 0) begin
                m_ready  <= 1'b0;
                rx_stall = rx_stall - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: checks taken results, then predicts for the accepted command.
    always @(posedge aclk) begin
        deque_result_t exp_res;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_taken <= results_taken + 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: result_value %0d", m_result_value);
                    failed = 1'b1;
                end else begin
                    exp_res = expected_results[0];
                    expected_results.delete(0);
                    if (m_result_value !== exp_res.value) begin
                        $error("result_value: expected %0d, actual %0d",
                               exp_res.value, m_result_value);
                        failed = 1'b1;
                    end
                    if (m_was_empty !== exp_res.was_empty) begin
                        $error("was_empty: expected %0b, actual %0b",
                               exp_res.was_empty, m_was_empty);
                        failed = 1'b1;
                    end
                    if (m_overflow_seen !== exp_res.overflow) begin
                        $error("overflow_seen: expected %0b, actual %0b",
                               exp_res.overflow, m_overflow_seen);
                        failed = 1'b1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_deque_command(deq_pkg::opcode_t'(s_opcode), s_push_value);
                cmds_taken <= cmds_taken + 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int total_cmds;
        int mood;
        int push_pct;

        // Everything on an empty queue, before any overflow.
        queue_command(deq_pkg::OP_POP_FRONT, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_POP_BACK, -32'sd1, 1'b0);
        queue_command(deq_pkg::OP_FRONT, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_BACK, -32'sd1, 1'b0);
        queue_command(deq_pkg::OP_SIZE, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_EMPTY, 32'sd0, 1'b0);
        // Field extremes, and a head pointer that wraps below zero.
        queue_command(deq_pkg::OP_PUSH_FRONT, 32'sh7fffffff, 1'b0);
        queue_command(deq_pkg::OP_PUSH_BACK, 32'sh80000000, 1'b0);
        queue_command(deq_pkg::OP_PUSH_FRONT, -32'sd1, 1'b0);
        queue_command(deq_pkg::OP_PUSH_BACK, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_PUSH_BACK, 32'sd1, 1'b0);
        queue_command(deq_pkg::OP_SIZE, 32'sd0, 1'b1);
        queue_command(deq_pkg::OP_EMPTY, 32'sh7fffffff, 1'b0);
        queue_command(deq_pkg::OP_FRONT, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_BACK, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_POP_FRONT, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_POP_BACK, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_POP_FRONT, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_POP_BACK, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_POP_FRONT, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_EMPTY, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_POP_BACK, 32'sd0, 1'b0);
        queue_command(deq_pkg::OP_BACK, 32'sd0, 1'b0);

        // Fill the store to the brim, then push into the full store.
        for (int i = 0; i < DEPTH + 8; i++) begin
            if (i % 97 == 50) begin
                queue_command(random_opcode(0), random_word(), 1'b0);
            end
            queue_command(random_opcode(100), random_word(), i == DEPTH - 1);
        end
        queue_command(deq_pkg::OP_SIZE, random_word(), 1'b0);
        queue_command(deq_pkg::OP_FRONT, random_word(), 1'b0);
        queue_command(deq_pkg::OP_BACK, random_word(), 1'b0);
        queue_command(deq_pkg::OP_EMPTY, random_word(), 1'b0);

        // Random traffic whose push share drifts so the depth swings.
        mood = 0;
        for (int n = 0; n < 200; n++) begin
            if (n % 60 == 0) mood = $urandom_range(0, 3);
            case (mood)
                0:       push_pct = 10;
                1:       push_pct = 35;
                2:       push_pct = 50;
                default: push_pct = 75;
            endcase
            queue_command(random_opcode(push_pct), random_word(),
                          $urandom_range(0, 149) == 0);
        end
        total_cmds = pending_cmds.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (cmds_taken != total_cmds) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (expected_results.size() != 0) failed = 1'b1;
        if (!failed) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/deq_pkg.sv
sv/deq_ram.sv
sv/deq_cmd.sv
sv/deq_rsp.sv
sv/double_ended_queue.sv
verif/tb_top.sv
